// ===== rtl/mlpq_pkg.sv =====
// Shared constants for the multilevel priority ready queue.
// No dependencies; used by the queue core under rtl/.
package mlpq_pkg;

   localparam int NUM_LEVELS_DEF = 16;
   localparam int POOL_DEPTH_DEF = 64;

   localparam int PID_W      = 8;
   localparam int LVL_IN_W   = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   typedef enum logic {
      CMD_PUT = 1'b0,
      CMD_GET = 1'b1
   } cmd_type;

endpackage

// ===== rtl/multilevel_priority_ready_queue_core.sv =====
// Multilevel FCFS ready queue: one linked queue per priority level, shared entry pool.
// Depends on mlpq_pkg and mlpq_first_set.
//
// A transfer is taken at a clock edge, and its result is loaded into the response register at
// that same edge, so it can leave from the next edge on. A new transfer is taken every cycle
// while the response side keeps up. While a response waits unaccepted, the request side is
// held off. The cycle holds a priority encode over the level bitmap and one over the free
// entry bitmap. Each level keeps its head and the entry after it in flops. The link memory
// has one write and one registered read port. A get refills its level's second entry through
// that read port, bypassed into the next cycle. No clearing pass is needed after reset. A put
// into a full pool is dropped with status set. A get with every level empty returns the idle
// id with the idle flag set.
module multilevel_priority_ready_queue_core #(
   parameter int NUM_LEVELS = mlpq_pkg::NUM_LEVELS_DEF,
   parameter int POOL_DEPTH = mlpq_pkg::POOL_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata[7:0] process_id, [11:8] priority_level, rest zero; tuser[0] command
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mlpq_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   // response: tdata[7:0] granted_process_id, [8] status, rest zero; tuser[0] gave_idle
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mlpq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,
   input  logic                            csr_wen,
   input  logic [mlpq_pkg::PID_W-1:0]      csr_wdata
);

   localparam int LVL_W = $clog2(NUM_LEVELS);
   localparam int ENT_W = $clog2(POOL_DEPTH);
   localparam int PID_W = mlpq_pkg::PID_W;
   localparam int LW    = (LVL_W > mlpq_pkg::LVL_IN_W) ? LVL_W : mlpq_pkg::LVL_IN_W;
   localparam int MEM_W = ENT_W + PID_W;

   // control state
   logic [PID_W-1:0]      idle_ff;
   logic                  rsp_valid_ff;
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [POOL_DEPTH-1:0] free_ff, free_in;
   logic                  pend_ff, pend_in;
   logic [LVL_W-1:0]      pend_lvl_ff, pend_lvl_in;

   // per-level head, second entry and tail
   logic [ENT_W-1:0] head_idx_ff [NUM_LEVELS];
   logic [ENT_W-1:0] head_idx_in [NUM_LEVELS];
   logic [PID_W-1:0] head_pid_ff [NUM_LEVELS];
   logic [PID_W-1:0] head_pid_in [NUM_LEVELS];
   logic [ENT_W-1:0] next_idx_ff [NUM_LEVELS];
   logic [ENT_W-1:0] next_idx_in [NUM_LEVELS];
   logic [PID_W-1:0] next_pid_ff [NUM_LEVELS];
   logic [PID_W-1:0] next_pid_in [NUM_LEVELS];
   logic [ENT_W-1:0] tail_idx_ff [NUM_LEVELS];
   logic [ENT_W-1:0] tail_idx_in [NUM_LEVELS];

   // link memory: entry e holds the index and id of the entry queued after e
   logic [MEM_W-1:0] link_mem [POOL_DEPTH];
   logic [MEM_W-1:0] mem_q_ff;
   logic             mem_we, mem_re;
   logic [ENT_W-1:0] mem_waddr, mem_raddr;
   logic [MEM_W-1:0] mem_wdata;

   // response register
   logic [PID_W-1:0] rsp_pid_ff, rsp_pid_in;
   logic             rsp_idle_ff, rsp_idle_in;
   logic             rsp_drop_ff, rsp_drop_in;

   logic                acc, is_get;
   logic [PID_W-1:0]    put_pid;
   logic [LW-1:0]       lvl_wide;
   logic [LVL_W-1:0]    put_lvl, top_lvl, op_lvl;
   logic                lvl_any, free_any;
   logic [ENT_W-1:0]    free_idx;
   logic [ENT_W-1:0]    head_idx_cur, tail_cur, next_eff_idx, mem_q_idx;
   logic [PID_W-1:0]    head_pid_cur, next_eff_pid, mem_q_pid;
   logic                nonempty_cur;

   mlpq_first_set #(.WIDTH(NUM_LEVELS)) u_level_enc (
      .bits  (nonempty_ff),
      .found (lvl_any),
      .index (top_lvl)
   );

   mlpq_first_set #(.WIDTH(POOL_DEPTH)) u_free_enc (
      .bits  (free_ff),
      .found (free_any),
      .index (free_idx)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign acc        = req_tvalid && req_tready;
   assign is_get     = (req_tuser == mlpq_pkg::CMD_GET);
   assign put_pid    = req_tdata[PID_W-1:0];

   // levels past the last one fold into the least urgent level
   assign lvl_wide = LW'(req_tdata[PID_W +: mlpq_pkg::LVL_IN_W]);
   assign put_lvl  = (lvl_wide >= LW'(NUM_LEVELS - 1)) ? LVL_W'(NUM_LEVELS - 1)
                                                       : lvl_wide[LVL_W-1:0];
   assign op_lvl   = is_get ? top_lvl : put_lvl;

   assign mem_q_idx    = mem_q_ff[MEM_W-1:PID_W];
   assign mem_q_pid    = mem_q_ff[PID_W-1:0];
   assign head_idx_cur = head_idx_ff[op_lvl];
   assign head_pid_cur = head_pid_ff[op_lvl];
   assign tail_cur     = tail_idx_ff[op_lvl];
   assign nonempty_cur = nonempty_ff[op_lvl];

   // refill read from last cycle lands now
   always_comb begin
      if (pend_ff && pend_lvl_ff == op_lvl) begin
         next_eff_idx = mem_q_idx;
         next_eff_pid = mem_q_pid;
      end else begin
         next_eff_idx = next_idx_ff[op_lvl];
         next_eff_pid = next_pid_ff[op_lvl];
      end
   end

   always_comb begin
      nonempty_in = nonempty_ff;
      free_in     = free_ff;
      head_idx_in = head_idx_ff;
      head_pid_in = head_pid_ff;
      next_idx_in = next_idx_ff;
      next_pid_in = next_pid_ff;
      tail_idx_in = tail_idx_ff;
      pend_in     = 1'b0;
      pend_lvl_in = pend_lvl_ff;
      mem_we      = 1'b0;
      mem_waddr   = tail_cur;
      mem_wdata   = {free_idx, put_pid};
      mem_re      = 1'b0;
      mem_raddr   = next_eff_idx;
      rsp_pid_in  = '0;
      rsp_idle_in = 1'b0;
      rsp_drop_in = 1'b0;

      if (pend_ff) begin
         next_idx_in[pend_lvl_ff] = mem_q_idx;
         next_pid_in[pend_lvl_ff] = mem_q_pid;
      end

      if (acc) begin
         if (is_get) begin
            if (!lvl_any) begin
               rsp_pid_in  = idle_ff;
               rsp_idle_in = 1'b1;
            end else begin
               rsp_pid_in             = head_pid_cur;
               free_in[head_idx_cur]  = 1'b1;
               if (head_idx_cur == tail_cur) begin
                  nonempty_in[op_lvl] = 1'b0;
               end else begin
                  head_idx_in[op_lvl] = next_eff_idx;
                  head_pid_in[op_lvl] = next_eff_pid;
                  // fetch the entry after the new head unless the new head is the tail
                  if (next_eff_idx != tail_cur) begin
                     mem_re      = 1'b1;
                     pend_in     = 1'b1;
                     pend_lvl_in = op_lvl;
                  end
               end
            end
         end else if (!free_any) begin
            rsp_drop_in = 1'b1;
         end else begin
            free_in[free_idx]   = 1'b0;
            tail_idx_in[op_lvl] = free_idx;
            if (!nonempty_cur) begin
               nonempty_in[op_lvl] = 1'b1;
               head_idx_in[op_lvl] = free_idx;
               head_pid_in[op_lvl] = put_pid;
            end else begin
               mem_we = 1'b1;
               if (head_idx_cur == tail_cur) begin
                  next_idx_in[op_lvl] = free_idx;
                  next_pid_in[op_lvl] = put_pid;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         nonempty_ff  <= '0;
         free_ff      <= '1;
         pend_ff      <= 1'b0;
         pend_lvl_ff  <= '0;
      end else begin
         if (csr_wen) begin
            idle_ff <= csr_wdata;
         end
         if (acc) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         nonempty_ff <= nonempty_in;
         free_ff     <= free_in;
         pend_ff     <= pend_in;
         pend_lvl_ff <= pend_lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      head_idx_ff <= head_idx_in;
      head_pid_ff <= head_pid_in;
      next_idx_ff <= next_idx_in;
      next_pid_ff <= next_pid_in;
      tail_idx_ff <= tail_idx_in;
      if (acc) begin
         rsp_pid_ff  <= rsp_pid_in;
         rsp_idle_ff <= rsp_idle_in;
         rsp_drop_ff <= rsp_drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= link_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mlpq_pkg::RSP_DATA_W - PID_W - 1){1'b0}}, rsp_drop_ff, rsp_pid_ff};
   assign rsp_tuser  = rsp_idle_ff;

   // a pending refill always belongs to a level holding at least two entries
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> nonempty_ff[pend_lvl_ff])
      else $error("refill pending for an empty level");

   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> head_idx_ff[pend_lvl_ff] != tail_idx_ff[pend_lvl_ff])
      else $error("refill pending for a level with a single entry");

   assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("link memory read and write in one cycle");

   assert property (@(posedge clock) disable iff (reset)
      acc && !is_get && free_any |=> !free_ff[$past(free_idx)])
      else $error("allocated entry still marked free");

endmodule

// ===== rtl/mlpq_first_set.sv =====
// Lowest-index set bit finder for a bitmap.
// Depends on nothing; used by the queue core for levels and free entries.
module mlpq_first_set #(
   parameter int  WIDTH = 16,
   localparam int IDX_W = $clog2(WIDTH)
) (
   input  logic [WIDTH-1:0] bits,
   output logic             found,
   output logic [IDX_W-1:0] index
);

   always_comb begin
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (bits[i]) begin
            index = IDX_W'(i);
         end
      end
   end

   assign found = |bits;

endmodule
